### hdl/one_wire_bus_master_defines.svh
// Assertion macros used by the one-wire master top level.
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Types and constants of the one-wire bus master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package owm_pkg;

  localparam int TIME_BITS = 10;
  localparam int CFG_W     = 10;
  localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int IDX_W     = 3;

  localparam logic [TIME_BITS-1:0] TICK_MAX = {TIME_BITS{1'b1}};

  localparam logic [IDX_W-1:0] REG_RESET_RELEASE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRESENCE_SAMPLE = 3'd1;
  localparam logic [IDX_W-1:0] REG_RESET_END       = 3'd2;
  localparam logic [IDX_W-1:0] REG_SLOT_RELEASE    = 3'd3;
  localparam logic [IDX_W-1:0] REG_SLOT_SAMPLE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_SLOT_END        = 3'd5;

  localparam logic [CFG_W-1:0] RESET_RELEASE_DEF   = 10'd400;
  localparam logic [CFG_W-1:0] PRESENCE_SAMPLE_DEF = 10'd466;
  localparam logic [CFG_W-1:0] RESET_END_DEF       = 10'd880;
  localparam logic [CFG_W-1:0] SLOT_RELEASE_DEF    = 10'd1;
  localparam logic [CFG_W-1:0] SLOT_SAMPLE_DEF     = 10'd10;
  localparam logic [CFG_W-1:0] SLOT_END_DEF        = 10'd55;

  localparam logic KIND_RESET = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RESET = 2'd1,
    PH_SLOT  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] reset_release_time;
    logic [CFG_W-1:0] presence_sample_time;
    logic [CFG_W-1:0] reset_end_time;
    logic [CFG_W-1:0] slot_release_time;
    logic [CFG_W-1:0] slot_sample_time;
    logic [CFG_W-1:0] slot_end_time;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic       kind;
    logic [7:0] tx_byte;
    logic       line_level;
  } tick_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       reset_status;
  } result_t;

  // Compare a tick count against a register at a common width.
  function automatic logic [CMP_W-1:0] ext_tick(input logic [TIME_BITS-1:0] t);
    ext_tick = CMP_W'(t);
  endfunction

  function automatic logic [CMP_W-1:0] ext_cfg(input logic [CFG_W-1:0] v);
    ext_cfg = CMP_W'(v);
  endfunction

endpackage

`default_nettype wire

### hdl/owm_cfg.sv
// ----------------------------------------------------------------------------
// owm_cfg
// Timing register file, written through the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module owm_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [owm_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [owm_pkg::CFG_W-1:0] cfg_data,
  output owm_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_release_time   <= owm_pkg::RESET_RELEASE_DEF;
      cfg.presence_sample_time <= owm_pkg::PRESENCE_SAMPLE_DEF;
      cfg.reset_end_time       <= owm_pkg::RESET_END_DEF;
      cfg.slot_release_time    <= owm_pkg::SLOT_RELEASE_DEF;
      cfg.slot_sample_time     <= owm_pkg::SLOT_SAMPLE_DEF;
      cfg.slot_end_time        <= owm_pkg::SLOT_END_DEF;
    end else if (cfg_valid && cfg_ready) begin
      // drop writes beyond the last register
      unique case (cfg_index)
        owm_pkg::REG_RESET_RELEASE:   cfg.reset_release_time   <= cfg_data;
        owm_pkg::REG_PRESENCE_SAMPLE: cfg.presence_sample_time <= cfg_data;
        owm_pkg::REG_RESET_END:       cfg.reset_end_time       <= cfg_data;
        owm_pkg::REG_SLOT_RELEASE:    cfg.slot_release_time    <= cfg_data;
        owm_pkg::REG_SLOT_SAMPLE:     cfg.slot_sample_time     <= cfg_data;
        owm_pkg::REG_SLOT_END:        cfg.slot_end_time        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/owm_step.sv
// ----------------------------------------------------------------------------
// owm_step
// Sequencer state of the bus master, advanced by one tick per enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module owm_step (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire owm_pkg::cfg_t   cfg,
  input  wire owm_pkg::tick_t  tick,
  output owm_pkg::result_t     res
);

  owm_pkg::phase_t                 phase, phase_next;
  logic [owm_pkg::TIME_BITS-1:0]   tick_count, tick_count_next;
  logic [2:0]                      bit_index, bit_index_next;
  logic [7:0]                      shift_reg, shift_reg_next;
  logic [7:0]                      last_rx, last_rx_next;
  logic                            status_flag, status_flag_next;
  logic                            sample_bit, sample_bit_next;

  // state after a possible start on this tick
  owm_pkg::phase_t                 ph;
  logic [2:0]                      bi;
  logic [7:0]                      sr;
  logic                            sb;
  logic [owm_pkg::TIME_BITS-1:0]   tc;
  logic [owm_pkg::TIME_BITS-1:0]   tc_inc;
  logic [owm_pkg::CMP_W-1:0]       t;
  logic                            reset_over;
  logic                            slot_over;
  logic                            sb_reset;
  logic                            sb_slot;
  logic [7:0]                      sr_shift;
  logic                            drive;
  logic                            done;

  always_comb begin
    ph = phase;
    bi = bit_index;
    sr = shift_reg;
    sb = sample_bit;
    tc = tick_count;
    if (phase == owm_pkg::PH_IDLE && tick.start_req) begin
      tc = '0;
      if (tick.kind == owm_pkg::KIND_RESET) begin
        ph = owm_pkg::PH_RESET;
        sb = 1'b1;
      end else begin
        ph = owm_pkg::PH_SLOT;
        bi = 3'd0;
        sr = tick.tx_byte;
        sb = tick.tx_byte[0];
      end
    end
  end

  assign t          = owm_pkg::ext_tick(tc);
  assign tc_inc     = (tc == owm_pkg::TICK_MAX) ? tc : tc + 1'b1;
  assign reset_over = (t >= owm_pkg::ext_cfg(cfg.reset_end_time)) ||
                      (tc == owm_pkg::TICK_MAX);
  assign slot_over  = (t >= owm_pkg::ext_cfg(cfg.slot_end_time)) ||
                      (tc == owm_pkg::TICK_MAX);
  assign sb_reset   = (t == owm_pkg::ext_cfg(cfg.presence_sample_time)) ?
                      tick.line_level : sb;
  assign sb_slot    = (t == owm_pkg::ext_cfg(cfg.slot_sample_time) && !tick.line_level) ?
                      1'b0 : sb;
  assign sr_shift   = {sb_slot, sr[7:1]};

  // next state
  always_comb begin
    phase_next       = ph;
    tick_count_next  = tc;
    bit_index_next   = bi;
    shift_reg_next   = sr;
    last_rx_next     = last_rx;
    status_flag_next = status_flag;
    sample_bit_next  = sb;
    unique case (ph)
      owm_pkg::PH_IDLE: ;
      owm_pkg::PH_RESET: begin
        sample_bit_next = sb_reset;
        if (reset_over) begin
          status_flag_next = sb_reset | ~tick.line_level;
          phase_next       = owm_pkg::PH_IDLE;
          tick_count_next  = '0;
        end else begin
          tick_count_next = tc_inc;
        end
      end
      owm_pkg::PH_SLOT: begin
        sample_bit_next = sb_slot;
        if (slot_over) begin
          shift_reg_next  = sr_shift;
          tick_count_next = '0;
          if (bi == owm_pkg::LAST_BIT) begin
            last_rx_next   = sr_shift;
            bit_index_next = 3'd0;
            phase_next     = owm_pkg::PH_IDLE;
          end else begin
            bit_index_next  = bi + 3'd1;
            sample_bit_next = sr_shift[0];
          end
        end else begin
          tick_count_next = tc_inc;
        end
      end
      default: phase_next = owm_pkg::PH_IDLE;
    endcase
  end

  // outputs of this tick
  always_comb begin
    drive = 1'b0;
    done  = 1'b0;
    unique case (ph)
      owm_pkg::PH_IDLE: ;
      owm_pkg::PH_RESET: begin
        if (reset_over) begin
          done = 1'b1;
        end else begin
          drive = (t < owm_pkg::ext_cfg(cfg.reset_release_time));
        end
      end
      owm_pkg::PH_SLOT: begin
        if (slot_over) begin
          done = (bi == owm_pkg::LAST_BIT);
        end else begin
          drive = (t < owm_pkg::ext_cfg(cfg.slot_release_time)) || !sr[0];
        end
      end
      default: ;
    endcase
  end

  assign res.drive_low    = drive;
  assign res.busy_res     = (phase_next != owm_pkg::PH_IDLE);
  assign res.done_res     = done;
  assign res.rx_byte      = last_rx_next;
  assign res.reset_status = status_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= owm_pkg::PH_IDLE;
      tick_count  <= '0;
      bit_index   <= 3'd0;
      shift_reg   <= 8'd0;
      last_rx     <= 8'd0;
      status_flag <= 1'b1;
      sample_bit  <= 1'b1;
    end else if (en) begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      bit_index   <= bit_index_next;
      shift_reg   <= shift_reg_next;
      last_rx     <= last_rx_next;
      status_flag <= status_flag_next;
      sample_bit  <= sample_bit_next;
    end
  end

endmodule

`default_nettype wire

### hdl/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire master for reset/presence and LSB-first byte transfers.
// ----------------------------------------------------------------------------
// Each input word on the s_ channel is one microsecond tick: the sampled
// line level plus an optional start request (tuser selects reset or byte
// transfer, a read sends 0xFF). Each tick yields exactly one result word on
// the m_ channel with the line drive, busy and done flags, the last received
// byte and the last reset status.
// Timing registers must be written on the cfg_ channel only while the master is
// idle; the block itself does not enforce this. cfg_ready is always high and
// indexes above five are dropped. A word accepted on s_ sits in the input register
// and goes through the sequencer into the result register when the output advances.
// Throughput is one tick per cycle while the receiver keeps m_tready high,
// limited by the single sequencer update per tick. s_tready stays high while
// m_tready is high; when the receiver stalls, the result is held and one more
// tick is buffered before s_tready drops. Reset returns the sequencer to idle with
// status 1, clears the received byte and restores the default timing registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "one_wire_bus_master_defines.svh"

module one_wire_bus_master (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [15:0]               s_tdata,  // start_req, tx_byte[7:0], line_level, zeros
  input  wire logic                      s_tuser,  // kind
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [15:0]                    m_tdata,  // drive_low, busy_res, done_res,
                                                   // rx_byte[7:0], reset_status, zeros
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [owm_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [owm_pkg::CFG_W-1:0] cfg_data
);

  owm_pkg::cfg_t    cfg;
  owm_pkg::tick_t   in_word;
  owm_pkg::result_t res;
  owm_pkg::result_t out_word;
  logic             in_vld;
  logic             adv;
  logic             step_en;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !in_vld || adv;
  assign step_en  = in_vld && adv;

  owm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owm_step u_step (
    .clk  (clk),
    .rst  (rst),
    .en   (step_en),
    .cfg  (cfg),
    .tick (in_word),
    .res  (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word.start_req  <= s_tdata[0];
      in_word.tx_byte    <= s_tdata[8:1];
      in_word.line_level <= s_tdata[9];
      in_word.kind       <= s_tuser;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_word <= res;
    end
  end

  assign m_tdata = {4'd0, out_word.reset_status, out_word.rx_byte,
                    out_word.done_res, out_word.busy_res, out_word.drive_low};

  `OWM_ASSERT_NEXT(a_step_fills_output, step_en, m_tvalid, "sequencer step lost its result")
  `OWM_ASSERT_NOW(a_ready_when_drained, m_tready, s_tready, "input stalled with output free")
  `OWM_ASSERT_NOW(a_done_not_busy, m_tvalid && out_word.done_res, !out_word.busy_res,
    "done reported while still busy")
  `OWM_ASSERT_NEXT(a_stall_holds_tick, in_vld && !adv, in_vld && $stable(in_word),
    "buffered tick changed during stall")

endmodule

`default_nettype wire
